FILE: rtl/core/y2r_pkg.sv
`timescale 1ns / 1ps

package y2r_pkg;

   // One 2x2 block of 4:2:0 video
   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } y2r_req_type;

   // Four RGB565 pixels of that block
   typedef struct packed {
      logic [15:0] pixel_top_left;
      logic [15:0] pixel_top_right;
      logic [15:0] pixel_bottom_left;
      logic [15:0] pixel_bottom_right;
   } y2r_rsp_type;

   // Coefficient set; cgu and cgv are stored as magnitudes and applied negated
   typedef struct packed {
      logic [17:0] crv;
      logic [17:0] cbu;
      logic [17:0] cgu;
      logic [17:0] cgv;
   } y2r_coef_type;

   // Per-block chroma offsets handed from the chroma unit to the pixel lanes
   typedef struct packed {
      logic signed [8:0] dr;
      logic signed [8:0] dg;
      logic signed [8:0] db;
   } y2r_offset_type;

   localparam logic [2:0] MatrixReset = 3'd6;

   localparam y2r_coef_type CoefTable [8] = '{
      '{18'd117504, 18'd138453, 18'd13954, 18'd34903},
      '{18'd117504, 18'd138453, 18'd13954, 18'd34903},
      '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
      '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
      '{18'd104448, 18'd132798, 18'd24759, 18'd53109},
      '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
      '{18'd104597, 18'd132201, 18'd25675, 18'd53279},
      '{18'd117579, 18'd136230, 18'd16907, 18'd35559}
   };

   // Chroma quotient: divide by 76309 with half-divisor rounding
   localparam logic [16:0] ChromaDivisor = 17'd76309;
   localparam logic [24:0] ChromaHalf    = 25'd38154;
   // floor(2^32 / 76309); estimate is exact or one low
   localparam logic [15:0] ChromaRecip   = 16'd56283;

   // Luma scaling
   localparam logic signed [27:0] LumaGain   = 28'sd76309;
   localparam logic signed [27:0] LumaRound  = 28'sd32768;
   localparam logic signed [9:0]  LumaOffset = 10'sd16;

endpackage

FILE: rtl/core/y2r_rnd_div.sv
`timescale 1ns / 1ps

// Rounded, sign-symmetric quotient coef * sample / 76309 over four stages
module y2r_rnd_div (
   input  logic              clock,
   input  logic [17:0]       coef,
   input  logic              coef_neg,
   input  logic signed [8:0] sample,
   output logic signed [8:0] quot
);
   import y2r_pkg::*;

   logic [7:0]  mag;
   logic [25:0] wide_prod;
   logic [24:0] prod_in, prod_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;

   logic [24:0] m_in, m1_ff, m2_ff;
   logic [40:0] est_wide;
   logic [7:0]  qest_in, qest1_ff, qest2_ff;

   logic [24:0] back_wide, back_ff;
   logic [24:0] rem;
   logic [7:0]  q_fix;
   logic signed [8:0] quot_in, quot_ff;

   // Stage 1: magnitude product
   always_comb begin
      mag       = sample[8] ? 8'(-sample) : sample[7:0];
      wide_prod = {8'd0, coef} * {18'd0, mag};
      prod_in   = wide_prod[24:0];
   end

   // Stage 2: add half divisor, estimate quotient by reciprocal
   always_comb begin
      m_in     = prod_ff + ChromaHalf;
      est_wide = {16'd0, m_in} * {25'd0, ChromaRecip};
      qest_in  = est_wide[39:32];
   end

   // Stage 3: multiply estimate back
   assign back_wide = {17'd0, qest1_ff} * {8'd0, ChromaDivisor};

   // Stage 4: correct estimate by one compare, apply sign
   always_comb begin
      rem     = m2_ff - back_ff;
      q_fix   = (rem >= {8'd0, ChromaDivisor}) ? qest2_ff + 8'd1 : qest2_ff;
      quot_in = neg3_ff ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
   end

   // Advance the data pipeline
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      neg1_ff  <= sample[8] ^ coef_neg;
      m1_ff    <= m_in;
      qest1_ff <= qest_in;
      neg2_ff  <= neg1_ff;
      m2_ff    <= m1_ff;
      qest2_ff <= qest1_ff;
      back_ff  <= back_wide;
      neg3_ff  <= neg2_ff;
      quot_ff  <= quot_in;
   end

   assign quot = quot_ff;

`ifndef SYNTHESIS
   // Reciprocal estimate is never more than one below the true quotient
   a_est_within_one: assert property (@(posedge clock)
      (back_ff <= m2_ff) |-> ((m2_ff - back_ff) < {7'd0, ChromaDivisor, 1'b0}))
      else $error("quotient estimate off by more than one");
`endif

endmodule

FILE: rtl/core/y2r_chroma.sv
`timescale 1ns / 1ps

// Chroma offsets for one block: four dividers and the green sum
module y2r_chroma (
   input  logic                     clock,
   input  y2r_pkg::y2r_coef_type    coef,
   input  logic signed [8:0]        u,
   input  logic signed [8:0]        v,
   output y2r_pkg::y2r_offset_type  offset
);
   import y2r_pkg::*;

   logic signed [8:0] q_r, q_b, q_gu, q_gv;
   logic signed [9:0] dg_sum;
   y2r_offset_type    offset_in, offset_ff;

   y2r_rnd_div u_div_r  (.clock(clock), .coef(coef.crv), .coef_neg(1'b0),
                         .sample(v), .quot(q_r));
   y2r_rnd_div u_div_b  (.clock(clock), .coef(coef.cbu), .coef_neg(1'b0),
                         .sample(u), .quot(q_b));
   y2r_rnd_div u_div_gu (.clock(clock), .coef(coef.cgu), .coef_neg(1'b1),
                         .sample(u), .quot(q_gu));
   y2r_rnd_div u_div_gv (.clock(clock), .coef(coef.cgv), .coef_neg(1'b1),
                         .sample(v), .quot(q_gv));

   // Sum the two green terms, hold red and blue alongside
   always_comb begin
      dg_sum       = 10'(q_gu) + 10'(q_gv);
      offset_in.dr = q_r;
      offset_in.dg = dg_sum[8:0];
      offset_in.db = q_b;
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
   end

   assign offset = offset_ff;

endmodule

FILE: rtl/core/y2r_pixel_lane.sv
`timescale 1ns / 1ps

// One pixel: scale luma plus offset for red, green and blue, then clamp
module y2r_pixel_lane (
   input  logic                    clock,
   input  logic [7:0]              luma,
   input  y2r_pkg::y2r_offset_type offset,
   output logic [2:0][7:0]         chan
);
   import y2r_pkg::*;

   logic signed [8:0]  d [3];
   logic signed [9:0]  s [3];
   logic signed [27:0] prod_in [3];
   logic signed [27:0] prod_ff [3];
   logic signed [27:0] val [3];
   logic [2:0][7:0]    chan_in, chan_ff;

   assign d[0] = offset.dr;
   assign d[1] = offset.dg;
   assign d[2] = offset.db;

   // Stage 1: offset luma and scale
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s[k]       = $signed({2'b00, luma}) + 10'(d[k]) - LumaOffset;
         prod_in[k] = 28'(s[k]) * LumaGain;
      end
   end

   // Stage 2: round, shift down and clamp to 0..255
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         val[k] = prod_ff[k] + LumaRound;
         if (val[k] < 0) begin
            chan_in[k] = 8'd0;
         end else if (val[k][27:16] > 12'd255) begin
            chan_in[k] = 8'd255;
         end else begin
            chan_in[k] = val[k][23:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= prod_in[k];
      end
      chan_ff <= chan_in;
   end

   assign chan = chan_ff;

`ifndef SYNTHESIS
   a_red_floor: assert property (@(posedge clock)
      (prod_ff[0] < -28'sd32768) |=> (chan_ff[0] == 8'd0))
      else $error("negative red sum not clamped to zero");
   a_blue_ceiling: assert property (@(posedge clock)
      (prod_ff[2] >= 28'sd16744448) |=> (chan_ff[2] == 8'd255))
      else $error("blue sum above range not clamped");
`endif

endmodule

FILE: rtl/core/yuv420_to_rgb565_converter_unit.sv
`timescale 1ns / 1ps

// YUV 4:2:0 to RGB565 converter: one 2x2 block in, four RGB565 pixels out.
// Input: an item is taken at a rising edge with start high and busy low;
// req_data carries the four luma bytes and the shared U,V pair. busy is
// high only while reset is asserted, so a new item may follow every clock.
// Output: rsp_strobe is high for one cycle with rsp_data holding the four
// pixels; the receiver takes it at the end of that cycle and cannot stall.
// The strobe follows the accept edge through the input register, the
// four-stage reciprocal divider, the green sum register, the two lane
// stages and the pack stage. Throughput: one item per clock, every
// unit fully pipelined. The color matrix is read from csr_wr_data on a
// clock with csr_wr_en high and applies to items accepted afterwards.
// Reset (synchronous) selects matrix 6 and empties the result pipeline;
// items in flight at reset are dropped.
module yuv420_to_rgb565_converter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  y2r_pkg::y2r_req_type req_data,
   output logic                 rsp_strobe,
   output y2r_pkg::y2r_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_wr_data
);
   import y2r_pkg::*;

   localparam int PipeDepth = 9;
   localparam int LumaDelay = 6;

   logic                 accept;
   logic [2:0]           matrix_in, matrix_ff;
   logic [PipeDepth-1:0] valid_in, valid_ff;

   y2r_coef_type         coef_ff;
   logic signed [8:0]    u_ff, v_ff;
   logic [3:0][7:0]      luma_in;
   logic [3:0][7:0]      luma_pipe_ff [LumaDelay];
   y2r_offset_type       offset;
   logic [2:0][7:0]      lane_chan [4];
   logic [3:0][15:0]     pix;
   y2r_rsp_type          rsp_in, rsp_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   // Matrix select register
   assign matrix_in = csr_wr_en ? csr_wr_data : matrix_ff;

   // Valid pipeline: shift accept flags toward the strobe
   assign valid_in = {valid_ff[PipeDepth-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MatrixReset;
         valid_ff  <= '0;
      end else begin
         matrix_ff <= matrix_in;
         valid_ff  <= valid_in;
      end
   end

   assign luma_in[0] = req_data.luma_top_left;
   assign luma_in[1] = req_data.luma_top_right;
   assign luma_in[2] = req_data.luma_bottom_left;
   assign luma_in[3] = req_data.luma_bottom_right;

   // Input register: coefficients, centered chroma, and the luma delay line
   always_ff @(posedge clock) begin
      coef_ff         <= CoefTable[matrix_ff];
      u_ff            <= 9'($signed({~req_data.chroma_blue[7], req_data.chroma_blue[6:0]}));
      v_ff            <= 9'($signed({~req_data.chroma_red[7], req_data.chroma_red[6:0]}));
      luma_pipe_ff[0] <= luma_in;
      for (int i = 1; i < LumaDelay; i++) begin
         luma_pipe_ff[i] <= luma_pipe_ff[i-1];
      end
   end

   y2r_chroma u_chroma (
      .clock  (clock),
      .coef   (coef_ff),
      .u      (u_ff),
      .v      (v_ff),
      .offset (offset)
   );

   // Four pixel lanes share the block's offsets
   for (genvar g = 0; g < 4; g++) begin : g_lane
      y2r_pixel_lane u_lane (
         .clock  (clock),
         .luma   (luma_pipe_ff[LumaDelay-1][g]),
         .offset (offset),
         .chan   (lane_chan[g])
      );
   end

   // Merge: pack the lane channels into RGB565
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pix[i] = {lane_chan[i][0][7:3], lane_chan[i][1][7:2], lane_chan[i][2][7:3]};
      end
      rsp_in.pixel_top_left     = pix[0];
      rsp_in.pixel_top_right    = pix[1];
      rsp_in.pixel_bottom_left  = pix[2];
      rsp_in.pixel_bottom_right = pix[3];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = valid_ff[PipeDepth-1];
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PipeDepth))
      else $error("result strobe without an accepted item");
   a_busy_only_in_reset: assert property (@(posedge clock)
      $fell(reset) |-> !busy && !rsp_strobe)
      else $error("busy or strobe right after reset");
`endif

endmodule
